>>> design/sorted_list_engine_assert.svh
// Assertion macros for the sorted list engine checker.
// Used by sle_checker.sv; expects clk and rst_n in the enclosing scope.
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SLE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_list_engine: assertion failed");

// Next-cycle implication, disabled in reset.
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_list_engine: assertion failed");

`endif

>>> design/sle_pkg.sv
// Package for the sorted list engine: widths, operation and status codes,
// cell control struct. No dependencies.
package sle_pkg;

    localparam int VALUE_W        = 32;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 5;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_state_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  key;
    } cell_ctl_t;

endpackage

>>> design/sle_if.sv
// Valid/ready channel interfaces for the sorted list engine.
// Depends on sle_pkg for field widths.
interface sle_req_if;
    import sle_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  entry;
    logic [COUNT_W-1:0]         count;
    logic                       last;

    modport source (output valid, output status, output entry, output count, output last,
                    input ready);
    modport sink   (input valid, input status, input entry, input count, input last,
                    output ready);
endinterface

>>> design/sle_cell.sv
// One slot of the sorted chain: compares against the key and takes a value
// from itself, the key, a neighbor or the head slot. Depends on sle_pkg.
module sle_cell
(
    input  logic                               clk,
    input  sle_pkg::cell_ctl_t                 ctl,
    input  logic                               occupied,
    input  logic                               tail,
    input  logic                               prev_after,
    input  logic signed [sle_pkg::VALUE_W-1:0] prev_slot,
    input  logic signed [sle_pkg::VALUE_W-1:0] next_slot,
    input  logic signed [sle_pkg::VALUE_W-1:0] head_slot,
    output logic                               after,
    output logic                               hit,
    output logic signed [sle_pkg::VALUE_W-1:0] slot
);
    import sle_pkg::*;

    logic signed [VALUE_W-1:0] slot_reg;
    logic signed [VALUE_W-1:0] slot_next;

    // after: this slot sits at or beyond the first stored value >= key
    assign after = !occupied || (slot_reg >= ctl.key);
    assign hit   = after && !prev_after && occupied && (slot_reg == ctl.key);
    assign slot  = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                if (prev_after)
                    slot_next = prev_slot;
                else if (after)
                    slot_next = ctl.key;
            end
            CELL_REMOVE:
            begin
                if (after)
                    slot_next = next_slot;
            end
            CELL_ROTATE:
            begin
                slot_next = tail ? head_slot : next_slot;
            end
            CELL_HOLD:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

>>> design/sorted_list_engine.sv
// Top level of the sorted list engine: chain of compare-and-shift cells,
// occupancy counter, dump sequencer, output register. Depends on sle_pkg,
// sle_if and sle_cell.
//
//   channel  modport   fields                        role
//   req      sink      mode, value                   operation in
//   rsp      source    status, entry, count, last    results out
//
// Insert, remove and the unused mode each give one result.
// A dump gives one result per stored value, one per cycle while rsp is not
// stalled, by rotating the chain past cell 0; an empty dump gives one result.
// rst_n clears the count, the sequencer and the output valid; slots are
// written before they are read. A stalled rsp holds the sequencer and the
// chain; req is taken again once the output register has room.
module sorted_list_engine
#(
    parameter int CAPACITY = sle_pkg::DEFAULT_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    sle_req_if.sink   req,
    sle_rsp_if.source rsp
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    fsm_state_t                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [IW-1:0]             idx_reg, idx_next;

    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] entry_reg, entry_next;
    logic [COUNT_W-1:0]        rcount_reg;
    logic                      last_reg, last_next;
    logic                      load;

    cell_ctl_t                 ctl;
    logic [CAPACITY-1:0]       after_vec;
    logic [CAPACITY-1:0]       hit_vec;
    logic signed [VALUE_W-1:0] slot_vec [CAPACITY];

    logic out_free, accept, full, found, dump_last;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == FSM_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign found     = |hit_vec;
    assign dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                      prev_after;
            logic signed [VALUE_W-1:0] prev_slot;
            logic signed [VALUE_W-1:0] next_slot;

            if (g == 0)
            begin : g_first
                assign prev_after = 1'b0;
                assign prev_slot  = '0;
            end
            else
            begin : g_mid
                assign prev_after = after_vec[g-1];
                assign prev_slot  = slot_vec[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_end
                assign next_slot = '0;
            end
            else
            begin : g_nxt
                assign next_slot = slot_vec[g+1];
            end

            sle_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (CW'(g) < count_reg),
                .tail       (CW'(g + 1) == count_reg),
                .prev_after (prev_after),
                .prev_slot  (prev_slot),
                .next_slot  (next_slot),
                .head_slot  (slot_vec[0]),
                .after      (after_vec[g]),
                .hit        (hit_vec[g]),
                .slot       (slot_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        load        = 1'b0;
        status_next = ST_DONE;
        entry_next  = '0;
        last_next   = 1'b1;
        ctl.op      = CELL_HOLD;
        ctl.key     = req.value;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    unique case (mode_t'(req.mode))
                        MODE_INSERT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctl.op     = CELL_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (found)
                            begin
                                ctl.op     = CELL_REMOVE;
                                count_next = count_reg - CW'(1);
                            end
                            else
                                status_next = ST_NOT_FOUND;
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                load       = 1'b0;
                                idx_next   = '0;
                                state_next = FSM_DUMP;
                            end
                        end
                        MODE_NOP:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            FSM_DUMP:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    status_next = ST_ENTRY;
                    entry_next  = slot_vec[0];
                    last_next   = dump_last;
                    ctl.op      = CELL_ROTATE;
                    idx_next    = idx_reg + IW'(1);
                    if (dump_last)
                        state_next = FSM_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
            rcount_reg <= COUNT_W'(count_next);
            last_reg   <= last_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.entry  = entry_reg;
    assign rsp.count  = rcount_reg;
    assign rsp.last   = last_reg;

endmodule

>>> design/sle_checker.sv
// Port-level checks for sorted_list_engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine_assert.svh.
`include "sorted_list_engine_assert.svh"

module sle_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [sle_pkg::STATUS_W-1:0]       rsp_status,
    input logic signed [sle_pkg::VALUE_W-1:0] rsp_entry,
    input logic [sle_pkg::COUNT_W-1:0]        rsp_count,
    input logic                               rsp_last
);
    import sle_pkg::*;

    logic [STATUS_W+VALUE_W+COUNT_W:0] rsp_payload;

    assign rsp_payload = {rsp_status, rsp_entry, rsp_count, rsp_last};

    // a stalled transaction keeps its payload
    `SLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
    // only dump entries carry a value
    `SLE_ASSERT_IMPL(a_entry_zero, rsp_valid && (rsp_status != ST_ENTRY), rsp_entry == '0)
    // single-result operations always close the transaction group
    `SLE_ASSERT_IMPL(a_single_last, rsp_valid && (rsp_status != ST_ENTRY), rsp_last)
    // empty report implies empty table
    `SLE_ASSERT_IMPL(a_empty_count, rsp_valid && (rsp_status == ST_EMPTY), rsp_count == '0)

endmodule

bind sorted_list_engine sle_checker u_sle_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_entry  (rsp.entry),
    .rsp_count  (rsp.count),
    .rsp_last   (rsp.last)
);
